// ===== src/smpq_pkg.sv =====
// shared types and constants for the sorted min priority queue
package smpq_pkg;

  localparam int SUM_BITS = 20;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic ins;
    logic rem;
  } smpq_op_t;

endpackage

// ===== src/smpq_cell.sv =====
// one storage cell of the sorted queue chain
module smpq_cell #(
  parameter int W     = 16,
  parameter int CNT_W = 5,
  parameter int IDX   = 0
) (
  input  logic             clk,
  input  smpq_pkg::smpq_op_t op,
  input  logic [W-1:0]     value,
  input  logic [CNT_W-1:0] count,
  input  logic [W-1:0]     left_entry,
  input  logic             left_gt,
  input  logic [W-1:0]     right_entry,
  output logic [W-1:0]     entry,
  output logic             gt
);

  logic [W-1:0] entry_r;
  logic [W-1:0] entry_nxt;
  logic         valid;

  assign valid = CNT_W'(IDX) < count;
  // empty slots count as larger than any value
  assign gt    = !valid || (entry_r > value);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (op.ins && gt) begin
      entry_nxt = left_gt ? left_entry : value;
    end else if (op.rem) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ===== src/sorted_min_priority_queue.sv =====
// top level of the sorted min priority queue (chain of compare and shift cells)
// the result is registered in the output register in the cycle after the input transaction is accepted
// throughput: one insert or remove per cycle, unless the output register is full and out_tready is low
// reset: count and sum cleared, output channel empty; cell contents are not cleared
// an output held by out_tready low stalls the input only when the output register is full
module sorted_min_priority_queue #(
  parameter int CAPACITY   = 16,
  parameter int VALUE_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // value
  input  logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  // cmd
  input  logic in_tuser,
  output logic out_tvalid,
  input  logic out_tready,
  // removed_value, item_count, value_sum
  output logic [((VALUE_BITS + $clog2(CAPACITY + 1) + smpq_pkg::SUM_BITS + 7) / 8) * 8 - 1:0]
               out_tdata,
  // status
  output logic [1:0] out_tuser
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int OUT_W = ((VALUE_BITS + CNT_W + smpq_pkg::SUM_BITS + 7) / 8) * 8;
  localparam int SW    = smpq_pkg::SUM_BITS;

  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [SW-1:0]         sum_r, sum_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [1:0]            status_r, status_nxt;
  logic [VALUE_BITS-1:0] removed_r, removed_nxt;

  logic [VALUE_BITS-1:0] value;
  logic                  accept;
  logic                  full;
  logic                  empty;
  smpq_pkg::smpq_op_t    op;

  logic [VALUE_BITS-1:0] entry [CAPACITY];
  logic                  gt    [CAPACITY];

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign value     = in_tdata[VALUE_BITS-1:0];
  assign full      = count_r == CNT_W'(CAPACITY);
  assign empty     = count_r == '0;
  assign op.ins    = accept && !in_tuser && !full;
  assign op.rem    = accept && in_tuser && !empty;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_BITS-1:0] left_entry;
    logic                  left_gt;
    logic [VALUE_BITS-1:0] right_entry;

    if (i == 0) begin : g_first
      assign left_entry = value;
      assign left_gt    = 1'b0;
    end else begin : g_mid
      assign left_entry = entry[i-1];
      assign left_gt    = gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_entry = entry[i];
    end else begin : g_inner
      assign right_entry = entry[i+1];
    end

    smpq_cell #(
      .W    (VALUE_BITS),
      .CNT_W(CNT_W),
      .IDX  (i)
    ) u_cell (
      .clk        (clk),
      .op         (op),
      .value      (value),
      .count      (count_r),
      .left_entry (left_entry),
      .left_gt    (left_gt),
      .right_entry(right_entry),
      .entry      (entry[i]),
      .gt         (gt[i])
    );
  end

  always_comb begin
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    status_nxt    = status_r;
    removed_nxt   = removed_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      out_valid_nxt = 1'b1;
      removed_nxt   = '0;
      status_nxt    = smpq_pkg::ST_OK;
      if (!in_tuser) begin
        if (full) begin
          status_nxt = smpq_pkg::ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
          sum_nxt   = sum_r + SW'(value);
        end
      end else begin
        if (empty) begin
          status_nxt = smpq_pkg::ST_EMPTY;
        end else begin
          count_nxt   = count_r - CNT_W'(1);
          sum_nxt     = sum_r - SW'(entry[0]);
          removed_nxt = entry[0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
    status_r  <= status_nxt;
    removed_r <= removed_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = OUT_W'({sum_r, count_r, removed_r});

endmodule
